>>> src/prfl_pkg.sv
// ----------------------------------------------------------------------------
// prfl_pkg: shared types and constants of the page replacement block
// Field widths, register map codes and the configuration bundle.
// ----------------------------------------------------------------------------
package prfl_pkg;

    localparam int PAGE_IN_W   = 16;
    localparam int FRAME_OUT_W = 4;
    localparam int TOTAL_W     = 32;
    localparam int FRAMES_W    = 5;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_POLICY_MODE   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    typedef struct packed {
        t_policy               policy_mode;
        logic [FRAMES_W-1:0]   frames_in_use;
    } t_cfg;

endpackage

>>> src/prfl_if.sv
// ----------------------------------------------------------------------------
// prfl_if: valid/ready channels of the page replacement block
// The request carries one page reference, the response one lookup result.
// ----------------------------------------------------------------------------
interface prfl_req_if import prfl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PAGE_IN_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface prfl_rsp_if import prfl_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic                   page_fault;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic [PAGE_IN_W-1:0]   evicted_page;
    logic [TOTAL_W-1:0]     fault_total;

    modport source (
        output valid, output hit, output page_fault, output frame_index,
        output evicted_page, output fault_total, input ready
    );
    modport sink (
        input valid, input hit, input page_fault, input frame_index,
        input evicted_page, input fault_total, output ready
    );
endinterface

>>> src/prfl_cfg.sv
// ----------------------------------------------------------------------------
// prfl_cfg: APB register file of the page replacement block
// Holds the replacement policy and the number of frames in use.
// ----------------------------------------------------------------------------
module prfl_cfg import prfl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;
    t_policy              r_policy_mode;
    logic [FRAMES_W-1:0]  r_frames_in_use;

    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_mode   <= POLICY_FIFO;
            r_frames_in_use <= FRAMES_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_POLICY_MODE:   r_policy_mode   <= t_policy'(pwdata[0]);
                REG_FRAMES_IN_USE: r_frames_in_use <= pwdata[FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_POLICY_MODE:   prdata = APB_DW'(r_policy_mode);
            REG_FRAMES_IN_USE: prdata = APB_DW'(r_frames_in_use);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.policy_mode   = r_policy_mode;
    assign o_cfg.frames_in_use = r_frames_in_use;

endmodule

>>> src/page_replacement_fifo_lru.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru: page-frame table with FIFO or LRU replacement
// A page reference enters on i_req (valid/ready); one result per reference
// leaves on o_rsp: hit, fault, frame, evicted page and running fault total.
// The APB port selects the policy and the number of frames in use; write it
// only while no reference is in flight.
// Each frame's page and age rank live in one synchronous RAM. A reference
// makes a single pass over all MAX_FRAMES entries, one entry per cycle: the
// pass writes back the rank update left by the previous reference and at the
// same time searches for a hit, a free frame and the replacement victim.
// A reference's result is registered in the DONE state once its pass has ended;
// no new reference is accepted before that, and the next one is accepted in
// the idle state that follows.
// The result register lets a new reference enter while o_rsp is stalled; that
// reference then waits before its final step until the result is taken.
// Reset empties all frames, zeroes the FIFO pointer and the fault total, and
// selects FIFO with 16 frames. No RAM clearing is needed.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru import prfl_pkg::*; #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    prfl_req_if.sink          i_req,
    prfl_rsp_if.source        o_rsp
);

    localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int N_W    = $clog2(MAX_FRAMES + 1);
    localparam int MEM_W  = PAGE_BITS + RANK_W;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_FRAMES - 1);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_cfg w_cfg;

    // Control state.
    t_state                r_state,      n_state;
    logic                  r_issue,      n_issue;
    logic                  r_d_vld,      n_d_vld;
    logic [MAX_FRAMES-1:0] r_valid,      n_valid;
    logic [IDX_W-1:0]      r_fifo_ptr,   n_fifo_ptr;
    logic [TOTAL_W-1:0]    r_fault_cnt,  n_fault_cnt;
    logic                  r_p_on,       n_p_on;
    logic                  r_out_valid,  n_out_valid;

    // Payload and pass bookkeeping.
    logic [PAGE_BITS-1:0]   r_page,       n_page;
    logic [N_W-1:0]         r_n,          n_n;
    logic [IDX_W-1:0]       r_fifo_tgt,   n_fifo_tgt;
    logic [IDX_W-1:0]       r_rd_idx,     n_rd_idx;
    logic [IDX_W-1:0]       r_d_idx,      n_d_idx;
    logic                   r_found,      n_found;
    logic [IDX_W-1:0]       r_hit_idx,    n_hit_idx;
    logic [RANK_W-1:0]      r_hit_rank,   n_hit_rank;
    logic                   r_have_free,  n_have_free;
    logic [IDX_W-1:0]       r_free_idx,   n_free_idx;
    logic [IDX_W-1:0]       r_best_idx,   n_best_idx;
    logic [RANK_W-1:0]      r_best_rank,  n_best_rank;
    logic [PAGE_BITS-1:0]   r_best_page,  n_best_page;
    logic [PAGE_BITS-1:0]   r_fifo_page,  n_fifo_page;
    logic [RANK_W-1:0]      r_fifo_rank,  n_fifo_rank;
    logic [IDX_W-1:0]       r_p_f,        n_p_f;
    logic [RANK_W-1:0]      r_p_old,      n_p_old;
    logic                   r_p_fill,     n_p_fill;
    logic [PAGE_BITS-1:0]   r_p_page,     n_p_page;
    logic [N_W-1:0]         r_p_n,        n_p_n;
    logic                   r_out_hit,    n_out_hit;
    logic                   r_out_fault,  n_out_fault;
    logic [FRAME_OUT_W-1:0] r_out_frame,  n_out_frame;
    logic [PAGE_IN_W-1:0]   r_out_evict,  n_out_evict;

    // Frame RAM: {page, age rank} per frame, registered read.
    logic [MEM_W-1:0] r_mem [MAX_FRAMES];
    logic [MEM_W-1:0] r_mem_q;

    logic [N_W-1:0]       w_n;
    logic                 w_accept;
    logic                 w_rd_en;
    logic [PAGE_BITS-1:0] w_q_page;
    logic [RANK_W-1:0]    w_q_rank;
    logic [PAGE_BITS-1:0] w_u_page;
    logic [RANK_W-1:0]    w_u_rank;
    logic                 w_in_win;
    logic                 w_v;
    logic [IDX_W-1:0]     w_f;
    logic [N_W-1:0]       w_f_inc;
    logic [IDX_W-1:0]     w_f_next;
    logic [PAGE_BITS-1:0] w_evict;

    prfl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Effective window: zero acts as one frame, anything above the table as all.
    always_comb begin
        if (w_cfg.frames_in_use == '0) begin
            w_n = N_W'(1);
        end else if (32'(w_cfg.frames_in_use) > 32'(MAX_FRAMES)) begin
            w_n = N_W'(MAX_FRAMES);
        end else begin
            w_n = N_W'(w_cfg.frames_in_use);
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid & (r_state == S_IDLE);
    assign w_rd_en     = (r_state == S_SCAN) & r_issue;

    assign w_q_page = r_mem_q[MEM_W-1:RANK_W];
    assign w_q_rank = r_mem_q[RANK_W-1:0];
    assign w_v      = r_valid[r_d_idx];
    assign w_in_win = (N_W'(r_d_idx) < r_n);

    // Apply the previous reference's update to the entry coming out of the RAM.
    always_comb begin
        w_u_page = w_q_page;
        w_u_rank = w_q_rank;
        if (r_p_on) begin
            if (r_d_idx == r_p_f) begin
                w_u_page = r_p_page;
                w_u_rank = '0;
            end else if (w_v && (N_W'(r_d_idx) < r_p_n) &&
                         (r_p_fill || (w_q_rank < r_p_old)) && (w_q_rank != RANK_MAX)) begin
                w_u_rank = w_q_rank + RANK_W'(1);
            end
        end
    end

    // Final decision for the reference once the pass is complete.
    always_comb begin
        w_evict = '0;
        if (r_found) begin
            w_f = r_hit_idx;
        end else if (r_have_free) begin
            w_f = r_free_idx;
        end else if (w_cfg.policy_mode == POLICY_LRU) begin
            w_f     = r_best_idx;
            w_evict = r_best_page;
        end else begin
            w_f     = r_fifo_tgt;
            w_evict = r_fifo_page;
        end
        w_f_inc  = N_W'(w_f) + N_W'(1);
        w_f_next = (w_f_inc >= r_n) ? '0 : IDX_W'(w_f_inc);
    end

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_d_vld     = 1'b0;
        n_valid     = r_valid;
        n_fifo_ptr  = r_fifo_ptr;
        n_fault_cnt = r_fault_cnt;
        n_p_on      = r_p_on;
        n_out_valid = r_out_valid;
        n_page      = r_page;
        n_n         = r_n;
        n_fifo_tgt  = r_fifo_tgt;
        n_rd_idx    = r_rd_idx;
        n_d_idx     = r_d_idx;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_hit_rank  = r_hit_rank;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_best_idx  = r_best_idx;
        n_best_rank = r_best_rank;
        n_best_page = r_best_page;
        n_fifo_page = r_fifo_page;
        n_fifo_rank = r_fifo_rank;
        n_p_f       = r_p_f;
        n_p_old     = r_p_old;
        n_p_fill    = r_p_fill;
        n_p_page    = r_p_page;
        n_p_n       = r_p_n;
        n_out_hit   = r_out_hit;
        n_out_fault = r_out_fault;
        n_out_frame = r_out_frame;
        n_out_evict = r_out_evict;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_page      = PAGE_BITS'(i_req.page_number);
                    n_n         = w_n;
                    n_fifo_tgt  = (N_W'(r_fifo_ptr) < w_n) ? r_fifo_ptr : '0;
                    n_rd_idx    = '0;
                    n_issue     = 1'b1;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    n_d_vld = 1'b1;
                    n_d_idx = r_rd_idx;
                    if (r_rd_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + IDX_W'(1);
                    end
                end
                if (r_d_vld) begin
                    if (w_in_win) begin
                        if (w_v) begin
                            if (!r_found && (w_u_page == r_page)) begin
                                n_found    = 1'b1;
                                n_hit_idx  = r_d_idx;
                                n_hit_rank = w_u_rank;
                            end
                        end else if (!r_have_free) begin
                            n_have_free = 1'b1;
                            n_free_idx  = r_d_idx;
                        end
                        // Oldest frame wins; on equal ranks the lower index stays.
                        if ((r_d_idx == '0) || (w_v && (w_u_rank > r_best_rank))) begin
                            n_best_idx  = r_d_idx;
                            n_best_rank = w_u_rank;
                            n_best_page = w_u_page;
                        end
                        if (r_d_idx == r_fifo_tgt) begin
                            n_fifo_page = w_u_page;
                            n_fifo_rank = w_u_rank;
                        end
                    end
                    if (r_d_idx == LAST_IDX) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_found;
                    n_out_fault = !r_found && !r_have_free;
                    n_out_frame = FRAME_OUT_W'(w_f);
                    n_out_evict = PAGE_IN_W'(w_evict);
                    n_p_on      = 1'b1;
                    n_p_f       = w_f;
                    n_p_page    = r_page;
                    n_p_n       = r_n;
                    n_p_fill    = 1'b0;
                    if (r_found) begin
                        n_p_old = r_hit_rank;
                    end else if (r_have_free) begin
                        n_p_old       = '0;
                        n_p_fill      = 1'b1;
                        n_valid[w_f]  = 1'b1;
                        n_fifo_ptr    = w_f_next;
                    end else begin
                        if (w_cfg.policy_mode == POLICY_LRU) begin
                            n_p_old = r_best_rank;
                        end else begin
                            n_p_old    = r_fifo_rank;
                            n_fifo_ptr = w_f_next;
                        end
                        if (r_fault_cnt != '1) begin
                            n_fault_cnt = r_fault_cnt + TOTAL_W'(1);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_valid     <= '0;
            r_fifo_ptr  <= '0;
            r_fault_cnt <= '0;
            r_p_on      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_d_vld     <= n_d_vld;
            r_valid     <= n_valid;
            r_fifo_ptr  <= n_fifo_ptr;
            r_fault_cnt <= n_fault_cnt;
            r_p_on      <= n_p_on;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page      <= n_page;
        r_n         <= n_n;
        r_fifo_tgt  <= n_fifo_tgt;
        r_rd_idx    <= n_rd_idx;
        r_d_idx     <= n_d_idx;
        r_found     <= n_found;
        r_hit_idx   <= n_hit_idx;
        r_hit_rank  <= n_hit_rank;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_best_idx  <= n_best_idx;
        r_best_rank <= n_best_rank;
        r_best_page <= n_best_page;
        r_fifo_page <= n_fifo_page;
        r_fifo_rank <= n_fifo_rank;
        r_p_f       <= n_p_f;
        r_p_old     <= n_p_old;
        r_p_fill    <= n_p_fill;
        r_p_page    <= n_p_page;
        r_p_n       <= n_p_n;
        r_out_hit   <= n_out_hit;
        r_out_fault <= n_out_fault;
        r_out_frame <= n_out_frame;
        r_out_evict <= n_out_evict;
    end

    // The write-back of entry k shares a cycle with the read of entry k+1, and
    // a pass only starts after the previous one has written its last entry, so
    // a read never meets an outstanding write to the same frame.
    always_ff @(posedge i_clk) begin
        if (r_d_vld) begin
            r_mem[r_d_idx] <= {w_u_page, w_u_rank};
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[r_rd_idx];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.page_fault   = r_out_fault;
    assign o_rsp.frame_index  = r_out_frame;
    assign o_rsp.evicted_page = r_out_evict;
    assign o_rsp.fault_total  = r_fault_cnt;

endmodule
